/* hdl/ifrp_pkg.sv */
// ----------------------------------------------------------------------------
// ifrp_pkg
// Types and constants shared by the IMU frame resync parser.
// ----------------------------------------------------------------------------
package ifrp_pkg;

  localparam int unsigned WIN_LEN  = 19;   // bytes in one frame
  localparam int unsigned FILL_W   = 5;    // fill count width, holds 0..WIN_LEN
  localparam int unsigned SUM_LEN  = 16;   // bytes 2..17 enter the checksum
  localparam logic [7:0]  HDR_BYTE = 8'hAA;

  // Element 0 is the oldest byte in the window.
  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic               frame_ok;
    logic [7:0]         sample_index;
    logic signed [15:0] yaw_centideg;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] accel_x_millig;
    logic signed [15:0] accel_y_millig;
    logic signed [15:0] accel_z_millig;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;
    logic [31:0]        last_good_time_ms;
  } out_t;

  // Decoded frame payload, zero when no good frame.
  typedef struct packed {
    logic [7:0]         sample_index;
    logic signed [15:0] yaw_centideg;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] accel_x_millig;
    logic signed [15:0] accel_y_millig;
    logic signed [15:0] accel_z_millig;
  } frame_t;

  typedef struct packed {
    logic header_hit;   // full window starting with two header bytes
    logic frame_good;   // header hit and checksum matches
  } chk_t;

endpackage

/* hdl/ifrp_frame_check.sv */
// ----------------------------------------------------------------------------
// ifrp_frame_check
// Header match, 8-bit checksum over bytes 2..17 and field decode of a window.
// ----------------------------------------------------------------------------
module ifrp_frame_check (
  input  ifrp_pkg::win_t   window,
  input  logic             full,
  output ifrp_pkg::chk_t   status,
  output ifrp_pkg::frame_t frame
);
  import ifrp_pkg::*;

  logic [7:0] lvl1 [8];
  logic [7:0] lvl2 [4];
  logic [7:0] lvl3 [2];
  logic [7:0] sum;

  // Registered-free adder tree, wrapping at 8 bits
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lvl1[i] = window[2 + 2*i] + window[3 + 2*i];
    end
    for (int i = 0; i < 4; i++) begin
      lvl2[i] = lvl1[2*i] + lvl1[2*i + 1];
    end
    for (int i = 0; i < 2; i++) begin
      lvl3[i] = lvl2[2*i] + lvl2[2*i + 1];
    end
    sum = lvl3[0] + lvl3[1];
  end

  always_comb begin
    status.header_hit = full && (window[0] == HDR_BYTE) && (window[1] == HDR_BYTE);
    status.frame_good = status.header_hit && (sum == window[SUM_LEN + 2]);
  end

  always_comb begin
    frame = '0;
    if (status.frame_good) begin
      frame.sample_index   = window[2];
      frame.yaw_centideg   = {window[4],  window[3]};
      frame.pitch_centideg = {window[6],  window[5]};
      frame.roll_centideg  = {window[8],  window[7]};
      frame.accel_x_millig = {window[10], window[9]};
      frame.accel_y_millig = {window[12], window[11]};
      frame.accel_z_millig = {window[14], window[13]};
    end
  end

endmodule

/* hdl/imu_frame_resync_parser.sv */
// ----------------------------------------------------------------------------
// imu_frame_resync_parser
// Byte-stream IMU frame parser with self-resynchronising 19-byte window.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): one received byte and its arrival
// time in ms per transaction. Output channel (out_valid/out_ready/out_item):
// exactly one result per input byte, in order.
// A full window starting AA AA whose byte sum over 2..17 equals byte 18 gives
// frame_ok with the decoded index and six signed words, bumps good_frames,
// latches the timestamp and empties the window. Header with a wrong sum
// bumps bad_frames and the window keeps sliding. Frame fields are zero
// otherwise; the counters always show the state after the byte.
// Each byte goes from the input register to the result register; the
// per-byte window update (shift, 16-byte adder tree, compare, counter update)
// is combinational between them. Throughput: one byte per cycle unless stalled.
// The input register and the result register each hold one transaction, so
// input stays open while a result waits; a stalled receiver backs up into
// in_ready after two transactions.
// Reset (rst, synchronous) empties the window and clears all counters and
// the last-good timestamp; both channels come up empty.
// ----------------------------------------------------------------------------
module imu_frame_resync_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ifrp_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ifrp_pkg::out_t out_item
);
  import ifrp_pkg::*;

  localparam logic [FILL_W-1:0] FillFull = FILL_W'(WIN_LEN);

  logic              s1_valid;
  in_t               s1_item;
  logic              advance;

  win_t              window;
  win_t              window_next;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_after;
  logic [FILL_W-1:0] fill_count_next;
  logic [31:0]       good_count;
  logic [31:0]       good_count_next;
  logic [31:0]       bad_count;
  logic [31:0]       bad_count_next;
  logic [31:0]       last_good_stamp;
  logic [31:0]       last_good_stamp_next;

  chk_t              status;
  frame_t            frame;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Always shifting in at the top gives the same window as filling by index
  assign window_next = {s1_item.data_byte, window[WIN_LEN-1:1]};
  assign fill_after  = (fill_count < FillFull) ? fill_count + 1'b1 : fill_count;

  ifrp_frame_check u_check (
    .window (window_next),
    .full   (fill_after == FillFull),
    .status (status),
    .frame  (frame)
  );

  always_comb begin
    fill_count_next      = fill_after;
    good_count_next      = good_count;
    bad_count_next       = bad_count;
    last_good_stamp_next = last_good_stamp;
    if (status.frame_good) begin
      fill_count_next      = '0;
      good_count_next      = good_count + 32'd1;
      last_good_stamp_next = s1_item.time_ms;
    end else if (status.header_hit) begin
      bad_count_next = bad_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      good_count      <= '0;
      bad_count       <= '0;
      last_good_stamp <= '0;
    end else if (advance) begin
      fill_count      <= fill_count_next;
      good_count      <= good_count_next;
      bad_count       <= bad_count_next;
      last_good_stamp <= last_good_stamp_next;
    end
    if (advance) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item.frame_ok          <= status.frame_good;
      out_item.sample_index      <= frame.sample_index;
      out_item.yaw_centideg      <= frame.yaw_centideg;
      out_item.pitch_centideg    <= frame.pitch_centideg;
      out_item.roll_centideg     <= frame.roll_centideg;
      out_item.accel_x_millig    <= frame.accel_x_millig;
      out_item.accel_y_millig    <= frame.accel_y_millig;
      out_item.accel_z_millig    <= frame.accel_z_millig;
      out_item.good_frames       <= good_count_next;
      out_item.bad_frames        <= bad_count_next;
      out_item.last_good_time_ms <= last_good_stamp_next;
    end
  end

endmodule

/* hdl/ifrp_checker.sv */
// ----------------------------------------------------------------------------
// ifrp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ifrp_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input ifrp_pkg::out_t out_item
);
  import ifrp_pkg::*;

  logic        out_fire;
  logic [31:0] prev_good;
  logic [31:0] prev_bad;
  logic [31:0] prev_stamp;

  assign out_fire = out_valid && out_ready;

  // Counter values of the last delivered transaction; zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_good  <= '0;
      prev_bad   <= '0;
      prev_stamp <= '0;
    end else if (out_fire) begin
      prev_good  <= out_item.good_frames;
      prev_bad   <= out_item.bad_frames;
      prev_stamp <= out_item.last_good_time_ms;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.frame_ok |->
      out_item.sample_index == 8'd0 && out_item.yaw_centideg == 16'sd0 &&
      out_item.pitch_centideg == 16'sd0 && out_item.roll_centideg == 16'sd0 &&
      out_item.accel_x_millig == 16'sd0 && out_item.accel_y_millig == 16'sd0 &&
      out_item.accel_z_millig == 16'sd0)
    else $error("frame fields set without a good frame");

  a_good_step: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> out_item.good_frames == prev_good + 32'(out_item.frame_ok) &&
      (out_item.frame_ok || out_item.last_good_time_ms == prev_stamp))
    else $error("good count or timestamp out of step");

  a_bad_step: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> out_item.bad_frames == prev_bad ||
      (!out_item.frame_ok && out_item.bad_frames == prev_bad + 32'd1))
    else $error("bad count out of step");

endmodule

bind imu_frame_resync_parser ifrp_checker u_ifrp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
